[rtl/htab_pkg.sv]
// shared constants, types and slot helpers for the handle table allocator
`default_nettype none
package htab_pkg;

	localparam int SLOTS   = 1024;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int WORD_W  = 32;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int WORDS   = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int HSLOT_W = 30;

	localparam logic [2:0] KIND_ADD     = 3'd0;
	localparam logic [2:0] KIND_KEEP    = 3'd1;
	localparam logic [2:0] KIND_RELEASE = 3'd2;
	localparam logic [2:0] KIND_REMOVE  = 3'd3;
	localparam logic [2:0] KIND_GET     = 3'd4;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_RETAIN  = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [31:0]       owner;
		logic [31:0]       refs;
	} store_wr_t;

	typedef struct packed {
		logic              rd;
		logic [WIDX_W-1:0] rd_widx;
		logic              set;
		logic              clr;
		logic [BIT_W-1:0]  bitpos;
		logic              wipe;
		logic [WIDX_W-1:0] wipe_widx;
	} map_cmd_t;

	typedef struct packed {
		logic              any_free;
		logic [WIDX_W-1:0] free_widx;
		logic [BIT_W-1:0]  free_bit;
		logic [WIDX_W-1:0] word_idx;
	} map_stat_t;

	function automatic logic [WIDX_W-1:0] word_of(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+BIT_W-1:0] e;
		e = {{BIT_W{1'b0}}, s};
		return e[WIDX_W+BIT_W-1:BIT_W];
	endfunction

	function automatic logic [BIT_W-1:0] bit_of(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+BIT_W-1:0] e;
		e = {{BIT_W{1'b0}}, s};
		return e[BIT_W-1:0];
	endfunction

	// bits that never count as free: slot zero and slots past the end
	function automatic logic [WORD_W-1:0] fixed_mask(input logic [WIDX_W-1:0] w);
		logic [WORD_W-1:0] m;
		int                s;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			s    = int'(w) * WORD_W + b;
			m[b] = (s == 0) || (s >= SLOTS);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[rtl/handle_table_allocator_core.sv]
// top level of the reference-counted handle table allocator
`default_nettype none
// The cycle a request is accepted issues the reads of the tag, count and occupancy
// memories, and the next cycle computes the result and writes the entry back, since these
// memories have a registered read. A result sits in an output register, so the next
// request is taken while it waits. After reset a clearing pass zeroes the memories, and
// no request is taken until it ends. Add finds the lowest free slot from a per-word full
// flag and one word of the occupancy bitmap; slot zero is never handed out.
module handle_table_allocator_core
	import htab_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] handle,
	input  wire logic [31:0] object_tag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic      [31:0] handle_out,
	output logic      [31:0] object_out,
	output logic      [1:0]  object_action
);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_HOLD} state_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] handle;
		logic [31:0] obj;
		logic [1:0]  act;
	} res_t;

	state_t            state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [2:0]        kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic              in_range_q;
	logic [31:0]       tag_q;
	logic              out_valid_q;
	res_t              res_q;
	res_t              pend_q;

	logic              accept;
	logic              out_free;
	logic              load_out;
	logic [SLOT_W-1:0] in_slot;
	logic              in_range;
	store_wr_t         st_wr;
	logic [31:0]       owner_rd;
	logic [31:0]       refs_rd;
	map_cmd_t          mcmd;
	map_stat_t         mstat;
	res_t              res_d;
	logic [WIDX_W+BIT_W-1:0] add_full;
	logic [SLOT_W-1:0] add_slot;
	logic [31:0]       refs_dec;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = ((state_q == ST_EXEC) || (state_q == ST_HOLD)) && out_free;
	assign in_slot  = handle[SLOT_W+1:2];
	assign in_range = handle[31:2] < HSLOT_W'(SLOTS);
	assign add_full = {mstat.word_idx, mstat.free_bit};
	assign add_slot = add_full[SLOT_W-1:0];
	assign refs_dec = refs_rd - 32'd1;

	htab_store u_store (
		.clk      (clk),
		.rd_en    (accept),
		.raddr    (in_slot),
		.wr       (st_wr),
		.owner_rd (owner_rd),
		.refs_rd  (refs_rd)
	);

	htab_free_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.stat   (mstat)
	);

	always_comb begin
		st_wr  = '0;
		mcmd   = '0;
		res_d  = '0;
		mcmd.rd      = accept;
		mcmd.rd_widx = (kind == KIND_ADD) ? mstat.free_widx : word_of(in_slot);
		mcmd.bitpos  = bit_of(slot_q);
		st_wr.addr   = slot_q;
		if (state_q == ST_CLEAR) begin
			st_wr.we       = 1'b1;
			st_wr.addr     = clr_q;
			mcmd.wipe      = clr_q < SLOT_W'(WORDS);
			mcmd.wipe_widx = clr_q[WIDX_W-1:0];
		end else if (state_q == ST_EXEC) begin
			priority if (kind_q == KIND_ADD) begin
				if ((tag_q != 32'd0) && mstat.any_free) begin
					res_d.ok     = 1'b1;
					res_d.handle = 32'({add_slot, 2'b00});
					res_d.obj    = tag_q;
					res_d.act    = ACT_RETAIN;
					st_wr.we     = 1'b1;
					st_wr.addr   = add_slot;
					st_wr.owner  = tag_q;
					st_wr.refs   = 32'd1;
					mcmd.set     = 1'b1;
					mcmd.bitpos  = mstat.free_bit;
				end else begin
					res_d.handle = '1;
				end
			end else if ((kind_q > KIND_GET) || !in_range_q) begin
				res_d = '0;
			end else begin
				unique case (kind_q)
					KIND_KEEP: begin
						res_d.ok    = 1'b1;
						res_d.obj   = owner_rd;
						st_wr.we    = 1'b1;
						st_wr.owner = owner_rd;
						st_wr.refs  = refs_rd + 32'd1;
					end
					KIND_RELEASE: begin
						st_wr.we = 1'b1;
						priority if (refs_dec != 32'd0) begin
							res_d.ok    = 1'b1;
							res_d.obj   = owner_rd;
							st_wr.owner = owner_rd;
							st_wr.refs  = refs_dec;
						end else if (owner_rd != 32'd0) begin
							// count reached zero on a live slot: free it
							res_d.ok  = 1'b1;
							res_d.obj = owner_rd;
							res_d.act = ACT_RELEASE;
							mcmd.clr  = 1'b1;
						end else begin
							res_d.ok = 1'b0;
						end
					end
					KIND_REMOVE: begin
						if (owner_rd != 32'd0) begin
							res_d.ok  = 1'b1;
							res_d.obj = owner_rd;
							res_d.act = ACT_RELEASE;
							st_wr.we  = 1'b1;
							mcmd.clr  = 1'b1;
						end
					end
					KIND_GET: begin
						if (owner_rd != 32'd0) begin
							res_d.ok  = 1'b1;
							res_d.obj = owner_rd;
							res_d.act = ACT_RETAIN;
						end
					end
					default: begin
						res_d = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			kind_q      <= KIND_ADD;
			slot_q      <= '0;
			in_range_q  <= 1'b0;
			tag_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			pend_q      <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						kind_q     <= kind;
						slot_q     <= in_slot;
						in_range_q <= in_range;
						tag_q      <= object_tag;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						res_q   <= res_d;
						state_q <= ST_IDLE;
					end else begin
						pend_q  <= res_d;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						res_q   <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = res_q.ok;
	assign handle_out    = res_q.handle;
	assign object_out    = res_q.obj;
	assign object_action = res_q.act;

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted request did not move to execute");

	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> ((object_action == ACT_NONE) && (object_out == 32'd0)))
		else $error("failed request reports an object");

	a_add_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok && (handle_out != 32'd0)) |->
		((handle_out[1:0] == 2'b00) && (handle_out[31:2] != 30'd0) &&
		(handle_out[31:2] < HSLOT_W'(SLOTS))))
		else $error("add returned a handle outside the table");
`endif

endmodule
`default_nettype wire

[rtl/htab_store.sv]
// tag and reference count memories, one registered read port and one write port
`default_nettype none
module htab_store
	import htab_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] raddr,
	input  wire store_wr_t         wr,
	output logic      [31:0]       owner_rd,
	output logic      [31:0]       refs_rd
);

	logic [31:0] owner_mem [SLOTS];
	logic [31:0] refs_mem  [SLOTS];
	logic [31:0] owner_rd_q;
	logic [31:0] refs_rd_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			owner_mem[wr.addr] <= wr.owner;
			refs_mem[wr.addr]  <= wr.refs;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			owner_rd_q <= owner_mem[raddr];
			refs_rd_q  <= refs_mem[raddr];
		end
	end

	assign owner_rd = owner_rd_q;
	assign refs_rd  = refs_rd_q;

endmodule
`default_nettype wire

[rtl/htab_free_map.sv]
// occupancy bitmap memory with per-word full flags and lowest-free-slot search
`default_nettype none
module htab_free_map
	import htab_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire map_cmd_t  cmd,
	output map_stat_t      stat
);

	logic [WORD_W-1:0] map_mem [WORDS];
	logic [WORD_W-1:0] rword_q;
	logic [WIDX_W-1:0] widx_q;
	logic [WORDS-1:0]  full_q;

	logic              wr_en;
	logic [WIDX_W-1:0] wr_widx;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] onehot;
	logic [WORD_W-1:0] free_vec;
	logic [WIDX_W-1:0] free_widx;
	logic [BIT_W-1:0]  free_bit;

	always_comb begin
		onehot  = '0;
		onehot[cmd.bitpos] = 1'b1;
		wr_en   = cmd.wipe || cmd.set || cmd.clr;
		wr_widx = cmd.wipe ? cmd.wipe_widx : widx_q;
		priority if (cmd.wipe) begin
			wr_data = '0;
		end else if (cmd.set) begin
			wr_data = rword_q | onehot;
		end else begin
			wr_data = rword_q & ~onehot;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_widx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rword_q <= map_mem[cmd.rd_widx];
			widx_q  <= cmd.rd_widx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				full_q[i] <= &fixed_mask(WIDX_W'(i));
			end
		end else if (wr_en) begin
			full_q[wr_widx] <= &(wr_data | fixed_mask(wr_widx));
		end
	end

	// lowest word with room, then lowest free bit of the word just read
	always_comb begin
		free_widx = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				free_widx = WIDX_W'(i);
			end
		end
		free_vec = ~(rword_q | fixed_mask(widx_q));
		free_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				free_bit = BIT_W'(b);
			end
		end
	end

	assign stat.any_free  = ~&full_q;
	assign stat.free_widx = free_widx;
	assign stat.free_bit  = free_bit;
	assign stat.word_idx  = widx_q;

endmodule
`default_nettype wire

[verif/tb_handle_table_allocator_core.sv]
// self-checking testbench for the reference-counted handle table allocator
module tb_handle_table_allocator_core;
	import htab_pkg::*;

	localparam logic [2:0] KIND_UNUSED5 = 3'd5;
	localparam logic [2:0] KIND_UNUSED6 = 3'd6;
	localparam logic [2:0] KIND_UNUSED7 = 3'd7;
	localparam int         IDLE_LIMIT   = 6000;
	localparam int         RANDOM_REQS  = 400;
	localparam int         REPLY_DEPTH  = 64;
	localparam int         ROW_DEPTH    = 32;

	typedef struct packed {
		logic        ok;
		logic [31:0] handle_out;
		logic [31:0] object_out;
		logic [1:0]  action;
	} htab_reply_t;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] handle;
		logic [31:0] tag;
		bit          typed;
		htab_reply_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  kind;
	logic [31:0] handle;
	logic [31:0] object_tag;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic [31:0] handle_out;
	logic [31:0] object_out;
	logic [1:0]  object_action;

	// shadow copy of the table
	logic [31:0] shadow_tag  [SLOTS];
	logic [31:0] shadow_refs [SLOTS];

	// expected replies in request order, as a ring indexed by running counts
	htab_reply_t reply_log [REPLY_DEPTH];
	int          reply_wr = 0;
	int          reply_rd = 0;
	stim_row_t   directed_rows [ROW_DEPTH];
	int          directed_count = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	int          issued = 0;
	bit          calm = 1'b0;

	handle_table_allocator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.handle        (handle),
		.object_tag    (object_tag),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.handle_out    (handle_out),
		.object_out    (object_out),
		.object_action (object_action)
	);

	always #6 clk = ~clk;

	function automatic htab_reply_t apply_table_op(input logic [2:0] k, input logic [31:0] h,
			input logic [31:0] t);
		htab_reply_t r;
		logic [31:0] slot;
		int unsigned idx;
		r    = '{1'b0, 32'h0, 32'h0, ACT_NONE};
		slot = h >> 2;
		if (k == KIND_ADD) begin
			r.handle_out = '1;
			if (t != 32'h0) begin
				// lowest free slot, slot zero is never handed out
				for (int s = 1; s < SLOTS; s++) begin
					if (shadow_tag[s] == 32'h0) begin
						shadow_tag[s]  = t;
						shadow_refs[s] = 32'd1;
						r = '{1'b1, 32'(s) << 2, t, ACT_RETAIN};
						return r;
					end
				end
			end
			return r;
		end
		if (k > KIND_GET || slot >= SLOTS)
			return r;
		idx = slot;
		case (k)
			KIND_KEEP: begin
				shadow_refs[idx] = shadow_refs[idx] + 32'd1;
				r = '{1'b1, 32'h0, shadow_tag[idx], ACT_NONE};
			end
			KIND_RELEASE: begin
				shadow_refs[idx] = shadow_refs[idx] - 32'd1;
				if (shadow_refs[idx] != 32'h0) begin
					r = '{1'b1, 32'h0, shadow_tag[idx], ACT_NONE};
				end else if (shadow_tag[idx] != 32'h0) begin
					r = '{1'b1, 32'h0, shadow_tag[idx], ACT_RELEASE};
					shadow_tag[idx] = 32'h0;
				end
			end
			KIND_REMOVE: begin
				if (shadow_tag[idx] != 32'h0) begin
					r = '{1'b1, 32'h0, shadow_tag[idx], ACT_RELEASE};
					shadow_tag[idx]  = 32'h0;
					shadow_refs[idx] = 32'h0;
				end
			end
			default: begin
				if (shadow_tag[idx] != 32'h0)
					r = '{1'b1, 32'h0, shadow_tag[idx], ACT_RETAIN};
			end
		endcase
		return r;
	endfunction

	task automatic queue_case(input logic [2:0] k, input logic [31:0] h, input logic [31:0] t,
			input bit typed, input htab_reply_t want);
		directed_rows[directed_count] = '{k, h, t, typed, want};
		directed_count++;
	endtask

	// one request: predict, idle a while, then hold it until taken
	task automatic issue(input logic [2:0] k, input logic [31:0] h, input logic [31:0] t,
			input bit typed, input htab_reply_t want);
		htab_reply_t predicted;
		int          gap;
		predicted = apply_table_op(k, h, t);
		reply_log[reply_wr % REPLY_DEPTH] = typed ? want : predicted;
		reply_wr++;
		issued++;
		if (issued % 40 == 0)
			calm = ($urandom_range(0, 2) == 0);
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		handle     <= h;
		object_tag <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic random_request(input bit wide, output logic [2:0] k, output logic [31:0] h,
			output logic [31:0] t);
		int unsigned pick;
		int unsigned slot;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			k = KIND_ADD;
		else if (pick < 45)
			k = KIND_KEEP;
		else if (pick < 65)
			k = KIND_RELEASE;
		else if (pick < 75)
			k = KIND_REMOVE;
		else if (pick < 92)
			k = KIND_GET;
		else
			k = 3'($urandom_range(KIND_UNUSED5, KIND_UNUSED7));
		// live slots sit low because add takes the lowest free one
		pick = $urandom_range(0, 99);
		if (pick < 70)
			slot = wide ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, 40);
		else if (pick < 85)
			slot = $urandom_range(0, SLOTS - 1);
		else
			slot = SLOTS + $urandom_range(0, 3);
		h = (pick < 92) ? ((32'(slot) << 2) | 32'($urandom_range(0, 3))) : $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			t = 32'h0;
		else if (pick < 12)
			t = '1;
		else
			t = $urandom;
	endtask

	task automatic fill_request(output logic [2:0] k, output logic [31:0] h,
			output logic [31:0] t);
		k = KIND_ADD;
		h = $urandom;
		t = $urandom;
		if (t == 32'h0)
			t = 32'd1;
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	initial begin
		logic [2:0]  k;
		logic [31:0] h;
		logic [31:0] t;
		htab_reply_t none;
		none = '0;
		for (int s = 0; s < SLOTS; s++) begin
			shadow_tag[s]  = 32'h0;
			shadow_refs[s] = 32'h0;
		end
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		kind       <= KIND_ADD;
		handle     <= 32'h0;
		object_tag <= 32'h0;

		queue_case(KIND_GET,     32'h0,        32'h0,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_ADD,     '1,           32'h0,        1, '{1'b0, '1, 32'h0, ACT_NONE});
		queue_case(KIND_ADD,     32'h0,        '1,           1, '{1'b1, 32'h4, '1, ACT_RETAIN});
		queue_case(KIND_ADD,     32'h0,        32'h1,        1, '{1'b1, 32'h8, 32'h1, ACT_RETAIN});
		queue_case(KIND_GET,     32'h7,        32'h0,        1, '{1'b1, 32'h0, '1, ACT_RETAIN});
		queue_case(KIND_KEEP,    32'h8,        32'h0,        1, '{1'b1, 32'h0, 32'h1, ACT_NONE});
		queue_case(KIND_RELEASE, 32'h8,        32'h0,        1, '{1'b1, 32'h0, 32'h1, ACT_NONE});
		queue_case(KIND_RELEASE, 32'h9,        32'h0,        1, '{1'b1, 32'h0, 32'h1, ACT_RELEASE});
		// count wraps below zero on an empty slot, then back up
		queue_case(KIND_RELEASE, 32'h8,        32'h0,        0, none);
		queue_case(KIND_KEEP,    32'h8,        32'h0,        0, none);
		queue_case(KIND_KEEP,    32'hC,        32'h0,        0, none);
		queue_case(KIND_RELEASE, 32'hE,        32'h0,        0, none);
		queue_case(KIND_REMOVE,  32'h4,        32'h0,        1, '{1'b1, 32'h0, '1, ACT_RELEASE});
		queue_case(KIND_REMOVE,  32'h4,        32'h0,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_GET,     32'h4,        32'h0,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_KEEP,    32'h0,        32'h0,        0, none);
		queue_case(KIND_RELEASE, 32'h3,        32'h0,        0, none);
		queue_case(KIND_KEEP,    '1,           32'h0,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_GET,     32'hFFF,      32'h0,        0, none);
		queue_case(KIND_GET,     32'h1000,     32'h0,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_UNUSED5, 32'h8,        32'h5,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_UNUSED6, 32'h0,        32'h0,        1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_UNUSED7, '1,           '1,           1, '{1'b0, 32'h0, 32'h0, ACT_NONE});
		queue_case(KIND_ADD,     32'h0,        32'h80000000, 1,
			'{1'b1, 32'h4, 32'h80000000, ACT_RETAIN});
		queue_case(KIND_REMOVE,  32'hFFC,      32'h0,        0, none);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < directed_count; i++)
			issue(directed_rows[i].kind, directed_rows[i].handle, directed_rows[i].tag,
				directed_rows[i].typed, directed_rows[i].want);
		for (int n = 0; n < RANDOM_REQS; n++) begin
			random_request(1'b0, k, h, t);
			issue(k, h, t, 1'b0, none);
		end
		// a run of adds to push occupancy into higher words
		for (int n = 0; n < 60; n++) begin
			fill_request(k, h, t);
			issue(k, h, t, 1'b0, none);
		end
		for (int n = 0; n < 50; n++) begin
			random_request(1'b1, k, h, t);
			issue(k, h, t, 1'b0, none);
		end
		for (int n = 0; n < 15; n++) begin
			fill_request(k, h, t);
			issue(k, h, t, 1'b0, none);
		end
		in_valid <= 1'b0;

		while (reply_rd != reply_wr)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && reply_rd == reply_wr)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial out_ready <= 1'b0;

	// result side: check each reply, then stall for a random while
	always @(posedge clk) begin
		htab_reply_t got;
		htab_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{ok, handle_out, object_out, object_action};
				if (reply_rd == reply_wr) begin
					flag_mismatch($sformatf("unexpected result ok=%0b handle=%h obj=%h act=%0d",
						got.ok, got.handle_out, got.object_out, got.action));
				end else begin
					want = reply_log[reply_rd % REPLY_DEPTH];
					reply_rd++;
					if (got.ok !== want.ok || got.handle_out !== want.handle_out ||
							got.object_out !== want.object_out || got.action !== want.action)
						flag_mismatch($sformatf(
							"expected ok=%0b handle=%h obj=%h act=%0d, got ok=%0b handle=%h obj=%h act=%0d",
							want.ok, want.handle_out, want.object_out, want.action,
							got.ok, got.handle_out, got.object_out, got.action));
				end
				stall_left = calm ? 0 : $urandom_range(0, 8);
				out_ready <= (stall_left == 0);
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= (stall_left == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog, allows for the clearing pass after reset
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule

[sim.f]
rtl/htab_pkg.sv
rtl/htab_store.sv
rtl/htab_free_map.sv
rtl/handle_table_allocator_core.sv
verif/tb_handle_table_allocator_core.sv
